// File: rtl/cosine_similarity_unit_macros.svh
// Assertion macros shared by the cosine similarity unit.
// Depends on nothing. Each macro expects signals clk and rst in scope.
`ifndef COSINE_SIMILARITY_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside of reset.
`define CSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define CSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/csu_pkg.sv
// Package of the cosine similarity unit: widths, state codes and the
// command and status structs between controller and datapath. No dependencies.
package csu_pkg;

  localparam int ELEM_BITS_DEF = 16;
  localparam int DOT_W         = 44;
  localparam int NORM_W        = 43;
  localparam int MAG_W         = 44;
  localparam int FLOOR_W       = 16;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd11;
  localparam int PROD_W        = 120;
  localparam int P_W           = 86;
  localparam int R_SHIFT       = 32;
  localparam int R_W           = PROD_W - R_SHIFT;
  localparam int Q_W           = 16;
  localparam int BIT_W         = 4;
  localparam int MUL_STEPS     = MAG_W;
  localparam int CNT_W         = 6;
  localparam int SIM_W         = 16;

  // Controller states, one-hot.
  typedef enum logic [11:0] {
    S_ACC    = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_MUL_P  = 12'b000000000100,
    S_LOAD_R = 12'b000000001000,
    S_MUL_R  = 12'b000000010000,
    S_SAVE_R = 12'b000000100000,
    S_LOAD_S = 12'b000001000000,
    S_MUL_S  = 12'b000010000000,
    S_LOAD_T = 12'b000100000000,
    S_MUL_T  = 12'b001000000000,
    S_CMP    = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             acc_en;
    logic             check;
    logic             ld_p;
    logic             ld_r;
    logic             save_r;
    logic             ld_s;
    logic             ld_t;
    logic             mul_step;
    logic             cmp;
    logic             out_load;
    logic [BIT_W-1:0] bit_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic degen;
    logic out_free;
  } status_t;

endpackage

// File: rtl/csu_in_if.sv
// Input channel of the cosine similarity unit: one element pair per transaction.
// Depends on csu_pkg.
interface csu_in_if import csu_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] elem_a;
  logic signed [ELEM_BITS-1:0] elem_b;
  logic                        last_element;

  modport source (output valid, elem_a, elem_b, last_element, input ready);
  modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

// File: rtl/csu_out_if.sv
// Output channel of the cosine similarity unit: one result per transaction.
// Depends on csu_pkg.
interface csu_out_if import csu_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SIM_W-1:0] similarity;
  logic                    degenerate;

  modport source (output valid, similarity, degenerate, input ready);
  modport sink   (input valid, similarity, degenerate, output ready);
endinterface

// File: rtl/csu_ctrl.sv
// Controller of the cosine similarity unit: sequences accumulation, the
// shift-add multiplies and the bitwise search. Depends on csu_pkg and the macros.
`include "cosine_similarity_unit_macros.svh"

module csu_ctrl import csu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [BIT_W-1:0] bit_idx, bit_idx_next;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_W'(MUL_STEPS - 1));

  // Next state and commands.
  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.bit_idx  = bit_idx;
    unique case (state)
      S_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check    = 1'b1;
        bit_idx_next = BIT_W'(Q_W - 1);
        if (status.degen) begin
          state_next = S_DONE;
        end else begin
          cmd.ld_p   = 1'b1;
          state_next = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          state_next = S_LOAD_R;
        end
      end
      S_LOAD_R: begin
        cmd.ld_r   = 1'b1;
        state_next = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          state_next = S_SAVE_R;
        end
      end
      S_SAVE_R: begin
        cmd.save_r = 1'b1;
        state_next = S_LOAD_S;
      end
      S_LOAD_S: begin
        cmd.ld_s   = 1'b1;
        state_next = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          state_next = S_LOAD_T;
        end
      end
      S_LOAD_T: begin
        cmd.ld_t   = 1'b1;
        state_next = S_MUL_T;
      end
      S_MUL_T: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (bit_idx == '0) begin
          state_next = S_DONE;
        end else begin
          bit_idx_next = bit_idx - BIT_W'(1);
          state_next   = S_LOAD_S;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  // Step counter of the shift-add multiplier.
  always_comb begin
    if (cmd.mul_step && !cnt_last) begin
      cnt_next = cnt + CNT_W'(1);
    end else begin
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_ACC;
      cnt     <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      bit_idx <= bit_idx_next;
    end
  end

  `CSU_ASSERT_NEXT(a_last_starts_check, in_valid && in_ready && in_last, state == S_CHECK, "last transaction did not start the result computation")
  `CSU_ASSERT_NEXT(a_load_returns_idle, cmd.out_load, state == S_ACC, "controller did not return to accumulation after a result")
  `CSU_ASSERT_IMPL(a_cnt_idle_zero, !cmd.mul_step, cnt == '0, "multiplier step count left over outside a multiply")

endmodule

// File: rtl/csu_datapath.sv
// Datapath of the cosine similarity unit: accumulators, shift-add multiplier,
// search register and output register. Depends on csu_pkg and the macros.
`include "cosine_similarity_unit_macros.svh"

module csu_datapath import csu_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic signed [ELEM_BITS-1:0] elem_a,
  input  logic signed [ELEM_BITS-1:0] elem_b,
  input  logic                        last_element,
  input  logic                        cfg_we,
  input  logic [FLOOR_W-1:0]          cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SIM_W-1:0]     out_similarity,
  output logic                        out_degenerate
);

  localparam int PR_W  = 2 * ELEM_BITS;
  localparam int SUM_W = ((PR_W > DOT_W) ? PR_W : DOT_W) + 1;

  logic [FLOOR_W-1:0]       norm_floor;
  logic signed [DOT_W-1:0]  dot_acc, dot_snap, dot_sat;
  logic [NORM_W-1:0]        norm_a_acc, norm_b_acc, na_snap, nb_snap, na_sat, nb_sat;
  logic signed [PR_W-1:0]   prod_ab, sq_a, sq_b;
  logic signed [SUM_W-1:0]  dot_sum;
  logic [SUM_W-1:0]         na_sum, nb_sum;
  logic [MAG_W-1:0]         mag;
  logic                     dot_neg, deg_reg;
  logic [PROD_W-1:0]        mul_a, mul_acc;
  logic [MAG_W-1:0]         mul_b;
  logic [P_W-1:0]           p_reg;
  logic [R_W-1:0]           r_reg;
  logic [Q_W-1:0]           q, cand;
  logic [Q_W:0]             odd;
  logic                     q_big;
  logic signed [SIM_W-1:0]  sim_val;

  // Element products and saturating sums.
  assign prod_ab = PR_W'(elem_a * elem_b);
  assign sq_a    = PR_W'(elem_a * elem_a);
  assign sq_b    = PR_W'(elem_b * elem_b);
  assign dot_sum = SUM_W'(dot_acc) + SUM_W'(prod_ab);
  assign na_sum  = SUM_W'(norm_a_acc) + SUM_W'($unsigned(sq_a));
  assign nb_sum  = SUM_W'(norm_b_acc) + SUM_W'($unsigned(sq_b));

  always_comb begin
    if (dot_sum[SUM_W-1:DOT_W-1] == '0 || dot_sum[SUM_W-1:DOT_W-1] == '1) begin
      dot_sat = dot_sum[DOT_W-1:0];
    end else if (dot_sum[SUM_W-1]) begin
      dot_sat = {1'b1, {(DOT_W-1){1'b0}}};
    end else begin
      dot_sat = {1'b0, {(DOT_W-1){1'b1}}};
    end
    na_sat = (na_sum[SUM_W-1:NORM_W] == '0) ? na_sum[NORM_W-1:0] : '1;
    nb_sat = (nb_sum[SUM_W-1:NORM_W] == '0) ? nb_sum[NORM_W-1:0] : '1;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_floor <= FLOOR_RESET;
    end else if (cfg_we) begin
      norm_floor <= cfg_wdata;
    end
  end

  // Accumulators; the last pair moves the totals into the snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc    <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
    end else if (cmd.acc_en) begin
      if (last_element) begin
        dot_acc    <= '0;
        norm_a_acc <= '0;
        norm_b_acc <= '0;
      end else begin
        dot_acc    <= dot_sat;
        norm_a_acc <= na_sat;
        norm_b_acc <= nb_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && last_element) begin
      dot_snap <= dot_sat;
      na_snap  <= na_sat;
      nb_snap  <= nb_sat;
    end
  end

  // Degenerate test and magnitude of the dot product.
  assign status.degen = (na_snap < NORM_W'(norm_floor)) || (nb_snap < NORM_W'(norm_floor)) ||
                        (na_snap == '0) || (nb_snap == '0);
  assign mag = dot_snap[DOT_W-1] ? MAG_W'(~dot_snap + DOT_W'(1)) : MAG_W'(dot_snap);

  // Search candidate and its odd factor 2q - 1.
  assign cand = q | (Q_W'(1) << cmd.bit_idx);
  assign odd  = {cand, 1'b0} - (Q_W + 1)'(1);

  // Shift-add multiplier, one bit of the narrow operand per cycle.
  always_ff @(posedge clk) begin
    if (cmd.ld_p) begin
      mul_a   <= PROD_W'(na_snap);
      mul_b   <= MAG_W'(nb_snap);
      mul_acc <= '0;
    end else if (cmd.ld_r) begin
      mul_a   <= PROD_W'(mag);
      mul_b   <= mag;
      mul_acc <= '0;
    end else if (cmd.ld_s) begin
      mul_a   <= PROD_W'(odd);
      mul_b   <= MAG_W'(odd);
      mul_acc <= '0;
    end else if (cmd.ld_t) begin
      mul_a   <= PROD_W'(p_reg);
      mul_b   <= mul_acc[MAG_W-1:0];
      mul_acc <= '0;
    end else if (cmd.mul_step) begin
      mul_acc <= mul_acc + (mul_b[0] ? mul_a : '0);
      mul_a   <= mul_a << 1;
      mul_b   <= mul_b >> 1;
    end
  end

  // Product of the norms and the squared dot product.
  always_ff @(posedge clk) begin
    if (cmd.ld_r) begin
      p_reg <= mul_acc[P_W-1:0];
    end
    if (cmd.save_r) begin
      r_reg <= mul_acc[R_W-1:0];
    end
  end

  // Result search, most significant bit first.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      q       <= '0;
      deg_reg <= status.degen;
      dot_neg <= dot_snap[DOT_W-1];
    end else if (cmd.cmp) begin
      if (mul_acc <= {r_reg, {R_SHIFT{1'b0}}}) begin
        q[cmd.bit_idx] <= 1'b1;
      end
    end
  end

  // Zero for a degenerate vector, else clamp the magnitude to one and apply the sign.
  assign q_big = q[Q_W-1];
  always_comb begin
    if (deg_reg) begin
      sim_val = '0;
    end else if (dot_neg) begin
      sim_val = q_big ? {1'b1, {(SIM_W-1){1'b0}}} : SIM_W'(-q);
    end else begin
      sim_val = q_big ? {1'b0, {(SIM_W-1){1'b1}}} : SIM_W'(q);
    end
  end

  // Output register.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_similarity <= sim_val;
      out_degenerate <= deg_reg;
    end
  end

  `CSU_ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_valid, "loaded result not presented")
  `CSU_ASSERT_IMPL(a_degen_is_zero, out_valid && out_degenerate, out_similarity == '0, "degenerate result is not zero")
  `CSU_ASSERT_NEXT(a_last_clears_acc, cmd.acc_en && last_element, dot_acc == '0 && norm_a_acc == '0 && norm_b_acc == '0, "accumulators not cleared after the last pair")

endmodule

// File: rtl/cosine_similarity_unit.sv
// Cosine similarity unit: element pairs stream in on the sample channel and
// one Q1.15 similarity per vector leaves on the result channel.
// Each sample transaction carries elem_a, elem_b and last_element; the unit
// accepts one per cycle while it accumulates the dot product and both
// squared norms. The transaction marked last closes the vector.
// After the last pair the unit stops taking samples while it computes:
// it goes straight to the result when a norm is below norm_floor or zero
// (result 0, degenerate 1); otherwise it runs the bit-serial shift-add
// multiplier and a 16-step search of the result, each step needing two
// multiplies. The result then sits in an output register until
// the receiver takes it; samples of the next vector are accepted meanwhile.
// When the next result is computed while that register is still full, the
// controller holds it and takes no samples until the register empties.
// cfg_we and cfg_wdata write norm_floor; the user must do so only while the unit is idle (not enforced by the block).
// Synchronous reset clears the accumulators, the controller and the output
// valid and sets norm_floor to 11.
// Depends on csu_pkg, the channel interfaces, csu_ctrl and csu_datapath.
module cosine_similarity_unit import csu_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  csu_in_if.sink             sample,
  csu_out_if.source          result,
  input  logic               cfg_we,
  input  logic [FLOOR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  csu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_last  (sample.last_element),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  csu_datapath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .elem_a         (sample.elem_a),
    .elem_b         (sample.elem_b),
    .last_element   (sample.last_element),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_similarity (result.similarity),
    .out_degenerate (result.degenerate)
  );

endmodule

// File: verif/csu_tb_if.sv
`timescale 1ns / 100ps
// Testbench types shared by the scoreboard and the top module; the channel
// interfaces csu_in_if and csu_out_if come from the RTL. Depends on csu_pkg.
package csu_tb_pkg;
  import csu_pkg::*;

  // One element pair as offered to the sample channel.
  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_element;
  } pair_t;

  // One expected or observed result.
  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    degenerate;
  } cosine_t;

  // Tracks the running sums and holds the expected cosine results in order.
  class cosine_scoreboard;
    logic [15:0]        floor_q;
    logic signed [43:0] dot_sum;
    logic [42:0]        norm_a_sum;
    logic [42:0]        norm_b_sum;
    cosine_t            pending_q[$];
    int                 mismatches;

    function new();
      floor_q = FLOOR_RESET;
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      mismatches = 0;
    endfunction

    function void set_floor(logic [15:0] v);
      floor_q = v;
    endfunction

    // Largest q in [0, 32768] with (2q-1)^2 * na * nb <= 4 * dot^2 * 2^30.
    function automatic logic [15:0] search_magnitude(logic [43:0] mag, logic [42:0] na,
                                                     logic [42:0] nb);
      logic [127:0] prod;
      logic [127:0] rhs;
      logic [127:0] odd;
      int lo;
      int hi;
      int mid;
      prod = 128'(na) * 128'(nb);
      rhs = (128'(mag) * 128'(mag)) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 128'(2 * mid - 1);
        if (prod * odd * odd <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo[16] ? 16'h8000 : lo[15:0];
    endfunction

    // Accumulate one accepted pair; on the last pair, queue the cosine.
    function void note_pair(pair_t p);
      logic signed [47:0] d;
      logic [47:0]        na;
      logic [47:0]        nb;
      logic [43:0]        mag;
      logic [16:0]        q;
      cosine_t            r;
      d = 48'(dot_sum) + 48'(32'(p.elem_a) * 32'(p.elem_b));
      if (d > 48'sh7FF_FFFF_FFFF) dot_sum = 44'sh7FF_FFFF_FFFF;
      else if (d < -48'sh800_0000_0000) dot_sum = 44'sh800_0000_0000;
      else dot_sum = d[43:0];
      na = 48'(norm_a_sum) + 48'(32'(p.elem_a) * 32'(p.elem_a));
      norm_a_sum = na > 48'h7FF_FFFF_FFFF ? 43'h7FF_FFFF_FFFF : na[42:0];
      nb = 48'(norm_b_sum) + 48'(32'(p.elem_b) * 32'(p.elem_b));
      norm_b_sum = nb > 48'h7FF_FFFF_FFFF ? 43'h7FF_FFFF_FFFF : nb[42:0];
      if (!p.last_element) return;
      if (norm_a_sum < 43'(floor_q) || norm_b_sum < 43'(floor_q) ||
          norm_a_sum == 0 || norm_b_sum == 0) begin
        r.similarity = '0;
        r.degenerate = 1'b1;
      end else begin
        mag = dot_sum < 0 ? -dot_sum : dot_sum;
        q = 17'(search_magnitude(mag, norm_a_sum, norm_b_sum));
        if (q == 0 && search_magnitude(mag, norm_a_sum, norm_b_sum) == 16'h8000) q = 17'h8000;
        if (dot_sum < 0) r.similarity = 16'(-q);
        else r.similarity = q > 17'd32767 ? 16'sd32767 : q[15:0];
        r.degenerate = 1'b0;
      end
      pending_q.push_back(r);
      dot_sum = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
    endfunction

    // Compare one observed cosine against the oldest expectation.
    function void check_result(cosine_t got);
      cosine_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", 0, got.similarity);
        return;
      end
      want = pending_q.pop_front();
      if (got.similarity !== want.similarity)
        report("similarity", want.similarity, got.similarity);
      if (got.degenerate !== want.degenerate)
        report("degenerate", want.degenerate, got.degenerate);
    endfunction

    function void report(string what, int want, int got);
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
      mismatches++;
    endfunction
  endclass
endpackage

// File: verif/tb_cosine_similarity_unit.sv
`timescale 1ns / 100ps
// Top of the cosine similarity unit testbench: clock, reset, stimulus and checking.
// Depends on csu_pkg, csu_tb_pkg, the channel interfaces and cosine_similarity_unit.
module tb_cosine_similarity_unit;
  import csu_pkg::*;
  import csu_tb_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int     DRAIN_CYCLES = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  longint      cycles;
  bit          calm;
  bit          hold_off;
  cosine_scoreboard sb;

  csu_in_if  sample ();
  csu_out_if result ();

  cosine_similarity_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample.sink),
    .result    (result.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Note each accepted sample transaction and check each result transaction.
  always @(posedge clk) begin
    if (!rst && sample.valid && sample.ready)
      sb.note_pair({sample.elem_a, sample.elem_b, sample.last_element});
    if (!rst && result.valid && result.ready)
      sb.check_result({result.similarity, result.degenerate});
  end

  // Result receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= !hold_off && (calm || $urandom_range(99) >= 15);
  end

  // Offer one pair and wait until it is accepted; valid stays up for the next pair.
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, bit last);
    while (!calm && $urandom_range(99) < 15) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.elem_a <= a;
    sample.elem_b <= b;
    sample.last_element <= last;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a random vector of the given length.
  task automatic send_vector(int len, int style);
    logic signed [15:0] a;
    logic signed [15:0] b;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      case (style)
        0: b = 16'($urandom);
        1: b = a;
        2: b = -a;
        default: b = 16'($urandom_range(7) - 4);
      endcase
      if (style == 3 && $urandom_range(1)) a = 16'($urandom_range(3) - 2);
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Stop offering, wait until every result is in, then let the unit settle.
  task automatic drain();
    sample.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_floor(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_floor(v);
  endtask

  // Receiver hold-off counted in its own process.
  task automatic stall_receiver(int n);
    hold_off = 1'b1;
    repeat (n) @(negedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    int sent;
    sb = new();
    cycles = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample.valid = 1'b0;
    sample.elem_a = '0;
    sample.elem_b = '0;
    sample.last_element = 1'b0;
    result.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed vectors under the reset floor.
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(-16'sh8000, -16'sh8000, 1'b1);
    send_pair(-16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, -16'sh8000, 1'b1);
    send_pair(16'sh0000, 16'sh1234, 1'b1);
    send_pair(16'sh0003, 16'sh0003, 1'b1);
    send_pair(16'sh0004, -16'sh0004, 1'b1);
    send_pair(16'sh0001, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0001, 1'b1);
    send_pair(16'sh4000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh4000, 1'b1);
    send_pair(16'sh5555, -16'sh2AAB, 1'b0);
    send_pair(-16'sh5556, 16'sh2AAA, 1'b1);
    drain();

    // Zero floor: only a truly empty norm is degenerate.
    write_floor(16'h0000);
    send_pair(16'sh0001, 16'sh0001, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(-16'sh0001, 16'sh0001, 1'b1);
    drain();

    // Highest floor.
    write_floor(16'hFFFF);
    send_pair(16'sh00FF, 16'sh00FF, 1'b1);
    send_pair(16'sh0100, 16'sh0100, 1'b1);
    send_pair(-16'sh8000, 16'sh0001, 1'b1);
    drain();

    // Back-pressure: the receiver stops while vectors keep coming.
    write_floor(16'd11);
    fork
      stall_receiver(6000);
      repeat (4) send_vector($urandom_range(1, 4), 0);
    join
    drain();

    // Random phases with varied floors; one phase runs without idling.
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_floor(16'h0000);
        2: write_floor(16'hFFFF);
        3: write_floor(16'($urandom));
        default: write_floor(16'($urandom_range(64)));
      endcase
      calm = (phase == 4);
      while (sent < (phase + 1) * 300) begin
        int len;
        len = $urandom_range(99) < 85 ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_vector(len, $urandom_range(3));
        sent += len;
      end
      drain();
    end

    // Vectors of full-scale elements push the result to its limits.
    calm = 1'b0;
    write_floor(16'd11);
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 16; k++)
        send_pair(i ? -16'sh8000 : 16'sh7FFF, -16'sh8000, k == 15);
    end
    for (int k = 0; k < 16; k++)
      send_pair(-16'sh8000, (k % 2) ? 16'sh7FFF : -16'sh8000, k == 15);
    drain();

    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
